// ===== hw/rtl/spd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the scrambled packet deframer
// Packet length, descramble key and the result word type used by the framer,
// the output buffer and the top level.
// ----------------------------------------------------------------------------
package spd_pkg;

   // packet geometry
   localparam int FrameLen          = 10;
   localparam int PayloadLen        = FrameLen - 1;
   localparam int PosWidth          = $clog2(FrameLen);
   localparam int CountWidthDefault = 16;
   localparam int OutCountWidth     = 16;

   // bit 7 of a received byte marks the start of a packet
   localparam int StartBit = 7;

   // checksum covers the low 7 bits of the running sum
   localparam int SumWidth = 7;

   localparam logic [PosWidth-1:0] LastPos = PosWidth'(FrameLen - 1);

   typedef logic [PayloadLen-1:0][7:0] payload_type;

   // one result word
   typedef struct packed {
      payload_type                payload;
      logic                       packet_ok;
      logic [OutCountWidth-1:0]   sync_errors;
      logic [OutCountWidth-1:0]   checksum_errors;
   } result_type;

   // fixed descramble key, one byte per packet position
   function automatic logic [7:0] key_byte(input logic [PosWidth-1:0] pos);
      logic [7:0] key;
      case (pos)
         4'd0:    key = 8'h4b;
         4'd1:    key = 8'h7f;
         4'd2:    key = 8'h1d;
         4'd3:    key = 8'h5e;
         4'd4:    key = 8'h3c;
         4'd5:    key = 8'h29;
         4'd6:    key = 8'h6a;
         4'd7:    key = 8'h79;
         4'd8:    key = 8'h5a;
         4'd9:    key = 8'h46;
         default: key = 8'h00;
      endcase
      return key;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scrambled_packet_deframer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scrambled_packet_deframer_core: serial packet deframer and descrambler
// Takes one received byte per word, collects ten-byte packets, descrambles
// them and checks the 7-bit checksum, giving one result word per packet.
// ----------------------------------------------------------------------------
// The block accepts one received byte per clock cycle while req_stall is low.
// A byte with bit 7 set starts a packet; a start in the middle of a packet
// bumps the sync error count and restarts the packet. Each byte is
// descrambled and added to a running 7-bit sum as it arrives, so the tenth
// byte of a packet produces its result word in the same cycle it is accepted;
// the word is registered in the output buffer before the rsp_ port. Results
// with a checksum mismatch are still delivered with rsp_packet_ok low. A
// two-entry output buffer lets the input keep flowing while one result waits;
// req_stall rises only when both entries are full. Error counters are
// COUNT_WIDTH bits wide, wrap, and show their low 16 bits on the result port.
// ----------------------------------------------------------------------------
module scrambled_packet_deframer_core #(
   parameter int COUNT_WIDTH = spd_pkg::CountWidthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // received bytes
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   // packet results
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_payload_byte_0,
   output      logic [7:0]  rsp_payload_byte_1,
   output      logic [7:0]  rsp_payload_byte_2,
   output      logic [7:0]  rsp_payload_byte_3,
   output      logic [7:0]  rsp_payload_byte_4,
   output      logic [7:0]  rsp_payload_byte_5,
   output      logic [7:0]  rsp_payload_byte_6,
   output      logic [7:0]  rsp_payload_byte_7,
   output      logic [7:0]  rsp_payload_byte_8,
   output      logic        rsp_packet_ok,
   output      logic [15:0] rsp_sync_errors,
   output      logic [15:0] rsp_checksum_errors
);
   import spd_pkg::*;

   logic       byte_accept;
   logic       buf_full;
   logic       new_valid;
   result_type new_word;
   result_type rsp_word;

   assign req_stall   = buf_full;
   assign byte_accept = req_valid && !buf_full;

   // framing, descrambling and checksum
   spd_framer #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_framer (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_rx_byte),
      .result_valid (new_valid),
      .result       (new_word)
   );

   // result register and skid entry
   spd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (new_valid),
      .in_word   (new_word),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

   // unpack the result word
   assign rsp_payload_byte_0  = rsp_word.payload[0];
   assign rsp_payload_byte_1  = rsp_word.payload[1];
   assign rsp_payload_byte_2  = rsp_word.payload[2];
   assign rsp_payload_byte_3  = rsp_word.payload[3];
   assign rsp_payload_byte_4  = rsp_word.payload[4];
   assign rsp_payload_byte_5  = rsp_word.payload[5];
   assign rsp_payload_byte_6  = rsp_word.payload[6];
   assign rsp_payload_byte_7  = rsp_word.payload[7];
   assign rsp_payload_byte_8  = rsp_word.payload[8];
   assign rsp_packet_ok       = rsp_word.packet_ok;
   assign rsp_sync_errors     = rsp_word.sync_errors;
   assign rsp_checksum_errors = rsp_word.checksum_errors;

endmodule
`default_nettype wire

// ===== hw/rtl/spd_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spd_framer: byte framing, descrambling and checksum
// Tracks the packet position, descrambles each byte as it arrives, keeps a
// running 7-bit sum and the two error counters, and builds the result word
// on the last byte of a packet.
// ----------------------------------------------------------------------------
module spd_framer #(
   parameter int COUNT_WIDTH = spd_pkg::CountWidthDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                byte_accept,
   input  wire logic [7:0]          rx_byte,
   output      logic                result_valid,
   output      spd_pkg::result_type result
);
   import spd_pkg::*;

   logic [PosWidth-1:0]    pos_ff,      pos_in;
   logic [SumWidth-1:0]    sum_ff,      sum_in;
   logic [COUNT_WIDTH-1:0] sync_cnt_ff, sync_cnt_in;
   logic [COUNT_WIDTH-1:0] chk_cnt_ff,  chk_cnt_in;
   payload_type            bytes_ff;

   logic [PosWidth-1:0] cur_pos;
   logic [PosWidth-1:0] wr_pos;
   logic                start_mark;
   logic [7:0]          plain;
   logic                last_byte;
   logic                sum_match;

   // position of this word; a start mark restarts at zero
   always_comb begin
      cur_pos    = (pos_ff > LastPos) ? '0 : pos_ff;
      start_mark = rx_byte[StartBit];
      wr_pos     = start_mark ? '0 : cur_pos;
      plain      = rx_byte ^ key_byte(wr_pos);
      last_byte  = (wr_pos == LastPos);
      sum_match  = (plain == {1'b0, sum_ff});
   end

   // next state of position, running sum and counters
   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      sync_cnt_in = sync_cnt_ff;
      chk_cnt_in  = chk_cnt_ff;
      if (byte_accept) begin
         pos_in = last_byte ? '0 : wr_pos + PosWidth'(1);
         sum_in = (wr_pos == '0) ? plain[SumWidth-1:0]
                                 : sum_ff + plain[SumWidth-1:0];
         if (start_mark && (cur_pos != '0)) begin
            sync_cnt_in = sync_cnt_ff + COUNT_WIDTH'(1);
         end
         if (last_byte && !sum_match) begin
            chk_cnt_in = chk_cnt_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         sync_cnt_ff <= '0;
         chk_cnt_ff  <= '0;
      end else begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         sync_cnt_ff <= sync_cnt_in;
         chk_cnt_ff  <= chk_cnt_in;
      end
   end

   // descrambled payload bytes, one register per position
   always_ff @(posedge clock) begin
      for (int k = 0; k < PayloadLen; k++) begin
         if (byte_accept && (wr_pos == PosWidth'(k))) begin
            bytes_ff[k] <= plain;
         end
      end
   end

   // result word on the last byte of a packet
   always_comb begin
      result_valid           = byte_accept && last_byte;
      result.payload         = bytes_ff;
      result.packet_ok       = sum_match;
      result.sync_errors     = OutCountWidth'(sync_cnt_in);
      result.checksum_errors = OutCountWidth'(chk_cnt_in);
   end

endmodule
`default_nettype wire

// ===== hw/rtl/spd_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spd_out_buf: result register with skid stage
// Holds the result word for the output channel; a second entry catches a new
// word while the output is stalled, and its fill stalls the input side.
// ----------------------------------------------------------------------------
module spd_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire spd_pkg::result_type in_word,
   output      logic                full,
   output      logic                out_valid,
   input  wire logic                out_stall,
   output      spd_pkg::result_type out_word
);
   import spd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;

   // move words toward the output when it is free
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !out_stall) begin
         out_valid_in  = skid_valid_ff || in_valid;
         out_in        = skid_valid_ff ? skid_ff : in_word;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for scrambled_packet_deframer_core
// Feeds received bytes through a queue-driven driver with bursty pacing,
// predicts every packet result in a local deframer model and checks each
// result word field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import spd_pkg::*;

   localparam int          ClockHalf    = 5;
   localparam int          ResetCycles  = 3;
   localparam int          SettleCycles = 8;
   localparam int          HoldCycles   = 300;
   localparam int unsigned CycleLimit   = 200_000;

   localparam logic [7:0] ScrambleKey [FrameLen] = '{
      8'h4b, 8'h7f, 8'h1d, 8'h5e, 8'h3c, 8'h29, 8'h6a, 8'h79, 8'h5a, 8'h46
   };

   // pacing styles for sender gaps and receiver stalls
   typedef enum logic [1:0] {PaceFull, PaceLight, PaceHeavy} pace_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_payload_byte_0, rsp_payload_byte_1, rsp_payload_byte_2;
   logic [7:0]  rsp_payload_byte_3, rsp_payload_byte_4, rsp_payload_byte_5;
   logic [7:0]  rsp_payload_byte_6, rsp_payload_byte_7, rsp_payload_byte_8;
   logic        rsp_packet_ok;
   logic [15:0] rsp_sync_errors;
   logic [15:0] rsp_checksum_errors;

   scrambled_packet_deframer_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_byte_0  (rsp_payload_byte_0),
      .rsp_payload_byte_1  (rsp_payload_byte_1),
      .rsp_payload_byte_2  (rsp_payload_byte_2),
      .rsp_payload_byte_3  (rsp_payload_byte_3),
      .rsp_payload_byte_4  (rsp_payload_byte_4),
      .rsp_payload_byte_5  (rsp_payload_byte_5),
      .rsp_payload_byte_6  (rsp_payload_byte_6),
      .rsp_payload_byte_7  (rsp_payload_byte_7),
      .rsp_payload_byte_8  (rsp_payload_byte_8),
      .rsp_packet_ok       (rsp_packet_ok),
      .rsp_sync_errors     (rsp_sync_errors),
      .rsp_checksum_errors (rsp_checksum_errors)
   );

   always #ClockHalf clock = ~clock;

   // bytes waiting to be sent and packet results still owed by the block
   logic [7:0] bytes_to_send [$];
   result_type packets_due [$];

   // local deframer state
   logic [7:0]  rx_frame [FrameLen] = '{default: 8'h00};
   logic [3:0]  frame_pos = 4'd0;
   logic [15:0] sync_count = 16'd0;
   logic [15:0] sum_fail_count = 16'd0;

   pace_type    send_pace = PaceLight;
   pace_type    recv_pace = PaceLight;
   logic        req_taken = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_run_left = 0;
   int          hold_req = 0;
   int          hold_ack = 0;
   int          hold_left = 0;
   int          mismatches = 0;
   int unsigned cycle_count = 0;

   // take one received byte into the model; a tenth byte yields a packet result
   task automatic deframe_byte(input logic [7:0] rx);
      logic [3:0] pos;
      logic [7:0] sum;
      result_type pkt;
      pos = (frame_pos >= FrameLen) ? 4'd0 : frame_pos;
      if (rx[StartBit]) begin
         if (pos != 4'd0) sync_count = sync_count + 16'd1;
         pos = 4'd0;
      end
      rx_frame[pos] = rx;
      pos = pos + 4'd1;
      if (pos < FrameLen) begin
         frame_pos = pos;
      end else begin
         frame_pos = 4'd0;
         sum = 8'h00;
         for (int k = 0; k < FrameLen; k++) rx_frame[k] = rx_frame[k] ^ ScrambleKey[k];
         for (int k = 0; k < PayloadLen; k++) begin
            sum = sum + rx_frame[k];
            pkt.payload[k] = rx_frame[k];
         end
         // checksum byte compared on all 8 bits against the 7-bit sum
         pkt.packet_ok = (rx_frame[FrameLen-1] == {1'b0, sum[6:0]});
         if (!pkt.packet_ok) sum_fail_count = sum_fail_count + 16'd1;
         pkt.sync_errors     = sync_count;
         pkt.checksum_errors = sum_fail_count;
         packets_due.push_back(pkt);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", name, $time, want, got);
      end
   endtask

   task automatic check_packet();
      result_type want;
      logic [7:0] got [PayloadLen];
      got = '{rsp_payload_byte_0, rsp_payload_byte_1, rsp_payload_byte_2,
              rsp_payload_byte_3, rsp_payload_byte_4, rsp_payload_byte_5,
              rsp_payload_byte_6, rsp_payload_byte_7, rsp_payload_byte_8};
      if (packets_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("result word with none expected at %0t", $time);
      end else begin
         want = packets_due.pop_front();
         for (int k = 0; k < PayloadLen; k++)
            check_field($sformatf("payload_byte_%0d", k), 16'(want.payload[k]), 16'(got[k]));
         check_field("packet_ok", 16'(want.packet_ok), 16'(rsp_packet_ok));
         check_field("sync_errors", want.sync_errors, rsp_sync_errors);
         check_field("checksum_errors", want.checksum_errors, rsp_checksum_errors);
      end
   endtask

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) check_packet();
         if (req_valid && !req_stall) deframe_byte(req_rx_byte);
      end
   end

   // driver: bursts of words with random gaps, held while stalled
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (bytes_to_send.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= bytes_to_send.pop_front();
            if (burst_left <= 1) begin
               case (send_pace)
                  PaceFull: begin
                     burst_left <= 1000;
                     gap_left   <= 0;
                  end
                  PaceLight: begin
                     burst_left <= $urandom_range(1, 16);
                     gap_left   <= $urandom_range(1, 4);
                  end
                  default: begin
                     burst_left <= $urandom_range(1, 4);
                     gap_left   <= $urandom_range(1, 12);
                  end
               endcase
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: runs of stall and free cycles, plus a requested long hold-off
   always @(negedge clock) begin
      if (hold_ack != hold_req) begin
         hold_ack  <= hold_req;
         hold_left <= HoldCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (recv_pace == PaceFull) begin
         rsp_stall <= 1'b0;
      end else if (stall_run_left != 0) begin
         stall_run_left <= stall_run_left - 1;
      end else begin
         rsp_stall <= !rsp_stall;
         if (!rsp_stall)
            stall_run_left <= (recv_pace == PaceLight) ? $urandom_range(0, 4)
                                                       : $urandom_range(0, 10);
         else
            stall_run_left <= (recv_pace == PaceLight) ? $urandom_range(0, 8)
                                                       : $urandom_range(0, 2);
      end
   end

   // one packet: start byte (optionally a start before it), body, checksum byte
   task automatic queue_packet(input logic [7:0] first_raw, input bit double_start,
                               input bit random_body, input logic [7:0] body_plain,
                               input bit good);
      logic [7:0] plain;
      logic [7:0] sum;
      if (double_start) bytes_to_send.push_back({1'b1, 7'($urandom)});
      bytes_to_send.push_back(first_raw);
      sum = first_raw ^ ScrambleKey[0];
      for (int k = 1; k < PayloadLen; k++) begin
         plain = random_body ? {1'b0, 7'($urandom)} : body_plain;
         sum   = sum + plain;
         bytes_to_send.push_back(plain ^ ScrambleKey[k]);
      end
      plain = {1'b0, sum[6:0]};
      if (!good) plain = plain ^ 8'($urandom_range(1, 127));
      bytes_to_send.push_back(plain ^ ScrambleKey[FrameLen-1]);
   endtask

   // mostly well-formed packets, some cut short, some line noise
   task automatic queue_random_bytes(input int count);
      int made;
      int pick;
      int len;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            queue_packet({1'b1, 7'($urandom)}, $urandom_range(0, 9) == 0, 1'b1, 8'h00,
                         $urandom_range(0, 4) != 0);
            made += 10;
         end else if (pick < 85) begin
            len = $urandom_range(0, 8);
            bytes_to_send.push_back({1'b1, 7'($urandom)});
            for (int k = 0; k < len; k++) bytes_to_send.push_back({1'b0, 7'($urandom)});
            made += len + 1;
         end else begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) bytes_to_send.push_back(8'($urandom));
            made += len;
         end
      end
   endtask

   // wait until every word is sent and every result is in
   task automatic drain();
      while (bytes_to_send.size() != 0 || req_valid || packets_due.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic run_segment(input pace_type send, input pace_type recv, input int count,
                              input bit hold);
      send_pace = send;
      recv_pace = recv;
      queue_random_bytes(count);
      if (hold) hold_req = hold_req + 1;
      drain();
   endtask

   // watchdog
   initial begin
      wait (cycle_count >= CycleLimit);
      $display("[scrambled_packet_deframer_core] ERROR");
      $finish;
   end

   initial begin
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: start in mid packet, extreme body bytes, packet without start mark
      bytes_to_send.push_back(8'hff);
      bytes_to_send.push_back(8'h7f);
      queue_packet(8'h80, 1'b0, 1'b0, 8'h7f, 1'b1);
      for (int k = 0; k < FrameLen; k++) bytes_to_send.push_back(k[0] ? 8'h7f : 8'h00);
      drain();

      // random traffic under varied pacing; one segment backs up the block
      run_segment(PaceFull,  PaceFull,  250, 1'b0);
      run_segment(PaceLight, PaceLight, 250, 1'b0);
      run_segment(PaceFull,  PaceLight, 250, 1'b1);
      run_segment(PaceHeavy, PaceHeavy, 250, 1'b0);
      run_segment(PaceLight, PaceFull,  250, 1'b0);
      run_segment(PaceFull,  PaceHeavy, 280, 1'b0);

      if (mismatches == 0)
         $display("[scrambled_packet_deframer_core] OK");
      else
         $display("[scrambled_packet_deframer_core] ERROR");
      $finish;
   end

endmodule
